// ----- design/lz_flag_byte_decompressor_defines.svh -----
`ifndef LZ_FLAG_BYTE_DECOMPRESSOR_DEFINES_SVH
`define LZ_FLAG_BYTE_DECOMPRESSOR_DEFINES_SVH

// same-cycle implication
`define LZFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LZFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lzfd_pkg.sv -----
package lzfd_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int LEN_BITS          = 24;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_DIST  = 2'd1,
        ERR_TRUNCATED = 2'd2,
        ERR_WRONG_CMD = 2'd3
    } t_err;

    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

// ----- design/lzfd_ram.sv -----
module lzfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lzfd_queue.sv -----
module lzfd_queue
    import lzfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_item  i_push_item,
    output logic   o_push_stall,
    input  logic   i_pop,
    output t_q_out o_head
);

    t_item      r_mem [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_stall = (r_cnt == 2'd2);
    assign push = i_push_valid && !o_push_stall;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rd];

endmodule

// ----- design/lzfd_core.sv -----
module lzfd_core
    import lzfd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    input  t_q_out              i_head,
    output logic                o_pop,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_copy_pending,
    output logic                o_finished,
    output logic [1:0]          o_error_code
);

    localparam int HB = $clog2(HISTORY_DEPTH);
    localparam int WB = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MASK = '1;

    typedef enum logic [5:0] {
        PH_FLAG     = 6'b000001,
        PH_CHUNK    = 6'b000010,
        PH_LITERAL  = 6'b000100,
        PH_TOK_HIGH = 6'b001000,
        PH_LONG     = 6'b010000,
        PH_COPY     = 6'b100000
    } t_phase;

    t_phase                r_phase,  n_phase;
    logic [8:0]            r_fs,     n_fs;
    logic [7:0]            r_tl,     n_tl;
    logic [7:0]            r_th,     n_th;
    logic [7:0]            r_lit,    n_lit;
    logic [12:0]           r_cl,     n_cl;
    logic [11:0]           r_cd,     n_cd;
    logic [COUNT_BITS-1:0] r_prod,   n_prod;
    logic [HB-1:0]         r_wr,     n_wr;
    logic [COUNT_BITS-1:0] r_limit;

    logic                  r_ob_valid;
    logic                  r_ob_outv;
    logic [7:0]            r_ob_lit;
    logic                  r_ob_ram;
    logic                  r_ob_byp;
    logic [7:0]            r_ob_byp_byte;
    logic                  r_ob_pend;
    logic                  r_ob_fin;
    t_err                  r_ob_err;
    logic [HB-1:0]         r_ob_wa;

    logic                  adv;
    logic                  step;
    logic                  s_outv;
    logic [7:0]            s_lit;
    logic                  s_ram;
    t_err                  s_err;
    logic [HB-1:0]         rd_addr;
    logic [HB:0]           rd_diff;
    logic [15:0]           tok;
    logic [11:0]           m_dist;
    logic                  m_bad;
    logic [8:0]            fs_sh;
    t_phase                ec_phase;
    logic [COUNT_BITS-1:0] prod1;
    logic [HB-1:0]         wr1;
    logic [7:0]            cur_byte;
    logic [7:0]            ram_q;
    logic [WB-1:0]         cfg_wide;

    assign adv   = !r_ob_valid || !i_res_stall;
    assign o_pop = adv;
    assign step  = adv && i_head.valid;

    assign tok      = {r_th, r_tl};
    assign m_dist   = (r_phase == PH_LONG) ? tok[15:4] : {i_head.item.data, r_tl[7:4]};
    assign m_bad    = (m_dist == 12'd0) || (COUNT_BITS'(m_dist) > r_prod);
    assign fs_sh    = {1'b0, r_fs[8:1]};
    assign ec_phase = (fs_sh <= 9'd1) ? PH_FLAG : PH_CHUNK;
    assign prod1    = r_prod + COUNT_BITS'(1);
    assign wr1      = (r_wr == HB'(HISTORY_DEPTH - 1)) ? '0 : r_wr + HB'(1);
    assign rd_diff  = {1'b0, r_wr} - (HB+1)'(r_cd);
    assign rd_addr  = rd_diff[HB] ? HB'(rd_diff + (HB+1)'(HISTORY_DEPTH)) : rd_diff[HB-1:0];

    always_comb begin
        n_phase = r_phase;
        n_fs    = r_fs;
        n_tl    = r_tl;
        n_th    = r_th;
        n_lit   = r_lit;
        n_cl    = r_cl;
        n_cd    = r_cd;
        n_prod  = r_prod;
        n_wr    = r_wr;
        s_outv  = 1'b0;
        s_lit   = 8'd0;
        s_ram   = 1'b0;
        s_err   = ERR_NONE;
        if (r_prod >= r_limit) begin
            if (r_phase == PH_LITERAL || r_phase == PH_COPY) begin
                n_lit   = 8'd0;
                n_cl    = 13'd0;
                n_fs    = fs_sh;
                n_phase = ec_phase;
                s_err   = ERR_TRUNCATED;
            end
        end else if (i_head.item.cmd == CMD_DRAIN) begin
            if (r_phase != PH_COPY) begin
                s_err = ERR_WRONG_CMD;
            end else begin
                s_outv = 1'b1;
                s_ram  = 1'b1;
                n_prod = prod1;
                n_wr   = wr1;
                n_cl   = r_cl - 13'd1;
                if (r_cl == 13'd1) begin
                    n_fs    = fs_sh;
                    n_phase = ec_phase;
                end else if (prod1 >= r_limit) begin
                    n_cl    = 13'd0;
                    n_fs    = fs_sh;
                    n_phase = ec_phase;
                    s_err   = ERR_TRUNCATED;
                end
            end
        end else begin
            unique case (r_phase)
                PH_FLAG: begin
                    n_fs    = {1'b1, i_head.item.data};
                    n_phase = PH_CHUNK;
                end
                PH_CHUNK: begin
                    if (r_fs[0]) begin
                        n_tl    = i_head.item.data;
                        n_phase = PH_TOK_HIGH;
                    end else begin
                        n_lit = i_head.item.data;
                        if (i_head.item.data == 8'd0) begin
                            n_fs    = fs_sh;
                            n_phase = ec_phase;
                        end else begin
                            n_phase = PH_LITERAL;
                        end
                    end
                end
                PH_LITERAL: begin
                    s_outv = 1'b1;
                    s_lit  = i_head.item.data;
                    n_prod = prod1;
                    n_wr   = wr1;
                    n_lit  = r_lit - 8'd1;
                    if (r_lit == 8'd1) begin
                        n_fs    = fs_sh;
                        n_phase = ec_phase;
                    end else if (prod1 >= r_limit) begin
                        n_lit   = 8'd0;
                        n_fs    = fs_sh;
                        n_phase = ec_phase;
                        s_err   = ERR_TRUNCATED;
                    end
                end
                PH_TOK_HIGH, PH_LONG: begin
                    if (r_phase == PH_TOK_HIGH) begin
                        n_th = i_head.item.data;
                    end
                    if (r_phase == PH_TOK_HIGH && !r_tl[3]) begin
                        n_phase = PH_LONG;
                    end else if (m_bad) begin
                        n_cl    = 13'd0;
                        n_fs    = fs_sh;
                        n_phase = ec_phase;
                        s_err   = ERR_BAD_DIST;
                    end else begin
                        n_cd    = m_dist;
                        n_phase = PH_COPY;
                        if (r_phase == PH_TOK_HIGH) begin
                            n_cl = 13'(r_tl[2:0]) + 13'd4;
                        end else begin
                            n_cl = 13'({tok[3:0], i_head.item.data}) + 13'd4;
                        end
                    end
                end
                PH_COPY: begin
                    s_err = ERR_WRONG_CMD;
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
        end
    end

    assign cur_byte = r_ob_ram ? (r_ob_byp ? r_ob_byp_byte : ram_q) : r_ob_lit;

    lzfd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_ob_valid && r_ob_outv),
        .i_waddr (r_ob_wa),
        .i_wdata (cur_byte),
        .i_re    (step && s_ram),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign cfg_wide = WB'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAG;
            r_fs       <= '0;
            r_tl       <= '0;
            r_th       <= '0;
            r_lit      <= '0;
            r_cl       <= '0;
            r_cd       <= '0;
            r_prod     <= '0;
            r_wr       <= '0;
            r_limit    <= '0;
            r_ob_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= (cfg_wide > WB'(COUNT_MASK)) ? COUNT_MASK
                                                        : COUNT_BITS'(cfg_wide);
            end
            if (step) begin
                r_phase <= n_phase;
                r_fs    <= n_fs;
                r_tl    <= n_tl;
                r_th    <= n_th;
                r_lit   <= n_lit;
                r_cl    <= n_cl;
                r_cd    <= n_cd;
                r_prod  <= n_prod;
                r_wr    <= n_wr;
            end
            if (adv) begin
                r_ob_valid <= i_head.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ob_outv     <= s_outv;
            r_ob_lit      <= s_lit;
            r_ob_ram      <= s_ram;
            r_ob_byp      <= r_ob_valid && r_ob_outv && (r_ob_wa == rd_addr);
            r_ob_byp_byte <= cur_byte;
            r_ob_pend     <= (n_phase == PH_COPY);
            r_ob_fin      <= (n_prod >= r_limit);
            r_ob_err      <= s_err;
            r_ob_wa       <= r_wr;
        end
    end

    assign o_res_valid    = r_ob_valid;
    assign o_out_valid    = r_ob_outv;
    assign o_out_byte     = cur_byte;
    assign o_copy_pending = r_ob_pend;
    assign o_finished     = r_ob_fin;
    assign o_error_code   = r_ob_err;

endmodule

// ----- design/lz_flag_byte_decompressor.sv -----
// channel   direction  handshake                      payload
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_data (total_length)
// in        in         i_in_valid / o_in_stall        i_cmd, i_in_byte
// res       out        o_res_valid / i_res_stall      o_out_valid, o_out_byte,
//                                                     o_copy_pending, o_finished,
//                                                     o_error_code
// One word per cycle sustained while the result is not stalled; an input word
// is registered in the queue, then in the result stage.
// History read is registered; a copy of the byte just written is
// forwarded from the result stage.
// Reset is synchronous, active low; history is not cleared.
// A stalled result holds the back part; a two-word queue keeps taking input until full.
module lz_flag_byte_decompressor
    import lzfd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [7:0]          i_in_byte,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_copy_pending,
    output logic                o_finished,
    output logic [1:0]          o_error_code
);

    t_item  in_item;
    t_q_out head;
    logic   pop;

    assign o_cfg_ready  = 1'b1;
    assign in_item.cmd  = i_cmd;
    assign in_item.data = i_in_byte;

    lzfd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .i_push_item  (in_item),
        .o_push_stall (o_in_stall),
        .i_pop        (pop),
        .o_head       (head)
    );

    lzfd_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_BITS    (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_head         (head),
        .o_pop          (pop),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_copy_pending (o_copy_pending),
        .o_finished     (o_finished),
        .o_error_code   (o_error_code)
    );

endmodule

// ----- design/lzfd_checker.sv -----
`include "lz_flag_byte_decompressor_defines.svh"

module lzfd_checker
    import lzfd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [LEN_BITS-1:0] i_cfg_data,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_cmd,
    input logic [7:0]          i_in_byte,
    input logic                o_res_valid,
    input logic                i_res_stall,
    input logic                o_out_valid,
    input logic [7:0]          o_out_byte,
    input logic                o_copy_pending,
    input logic                o_finished,
    input logic [1:0]          o_error_code
);

    `LZFD_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && i_res_stall, o_res_valid && $stable(o_out_byte), "stalled result changed")
    `LZFD_ASSERT_NOW(a_zero_byte, i_clk, i_rst_n, o_res_valid && !o_out_valid, o_out_byte == 8'd0, "byte without data not zero")
    `LZFD_ASSERT_NOW(a_err_no_byte, i_clk, i_rst_n, o_res_valid && (o_error_code == ERR_WRONG_CMD || o_error_code == ERR_BAD_DIST), !o_out_valid && !o_finished, "error word carries a byte")
    `LZFD_ASSERT_NOW(a_trunc_end, i_clk, i_rst_n, o_res_valid && o_error_code == ERR_TRUNCATED, !o_copy_pending && o_finished, "truncation left a copy open")

endmodule

bind lz_flag_byte_decompressor lzfd_checker u_lzfd_checker (.*);

// ----- dv/lz_flag_byte_decompressor_tb.sv -----
module lz_flag_byte_decompressor_tb;
    import lzfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       copy_pending;
        logic       finished;
        t_err       err;
    } t_dec_res;

    typedef enum logic [2:0] {
        PH_FLAG, PH_CHUNK, PH_LITERAL, PH_TOK_HIGH, PH_LONG, PH_COPY
    } t_phase;

    class lz_scoreboard;
        t_phase          phase;
        logic [8:0]      flag_bits;
        logic [7:0]      tok_lo;
        logic [7:0]      tok_hi;
        logic [7:0]      lit_left;
        logic [12:0]     copy_left;
        logic [11:0]     copy_dist;
        logic [23:0]     produced;
        logic [23:0]     total_len;
        logic [7:0]      hist [4096];
        t_dec_res        pending_q [$];
        int              mismatches;

        function void clear();
            phase = PH_FLAG;
            flag_bits = '0;
            tok_lo = '0;
            tok_hi = '0;
            lit_left = '0;
            copy_left = '0;
            copy_dist = '0;
            produced = '0;
            total_len = '0;
            mismatches = 0;
            pending_q.delete();
        endfunction

        function bit done();
            return produced >= total_len;
        endfunction

        function void end_chunk();
            flag_bits = flag_bits >> 1;
            phase = (flag_bits <= 9'd1) ? PH_FLAG : PH_CHUNK;
        endfunction

        function t_err start_match(logic [11:0] mdist, logic [12:0] len);
            if (mdist == 0 || 24'(mdist) > produced) begin
                copy_left = '0;
                end_chunk();
                return ERR_BAD_DIST;
            end
            copy_dist = mdist;
            copy_left = len;
            phase = PH_COPY;
            return ERR_NONE;
        endfunction

        function void put_byte(logic [7:0] b);
            hist[produced[11:0]] = b;
            produced = produced + 1;
        endfunction

        function void note_word(logic cmd, logic [7:0] b);
            t_dec_res    r;
            logic [15:0] tok;
            r = '0;
            r.err = ERR_NONE;
            tok = {tok_hi, tok_lo};
            if (done()) begin
                if (phase == PH_LITERAL || phase == PH_COPY) begin
                    lit_left = '0;
                    copy_left = '0;
                    end_chunk();
                    r.err = ERR_TRUNCATED;
                end
            end else if (cmd == CMD_DRAIN) begin
                if (phase != PH_COPY) begin
                    r.err = ERR_WRONG_CMD;
                end else begin
                    r.out_byte = hist[produced[11:0] - copy_dist];
                    r.out_valid = 1'b1;
                    put_byte(r.out_byte);
                    copy_left = copy_left - 1;
                    if (copy_left == 0) begin
                        end_chunk();
                    end else if (done()) begin
                        copy_left = '0;
                        end_chunk();
                        r.err = ERR_TRUNCATED;
                    end
                end
            end else begin
                case (phase)
                    PH_FLAG: begin
                        flag_bits = {1'b1, b};
                        phase = PH_CHUNK;
                    end
                    PH_CHUNK: begin
                        if (flag_bits[0]) begin
                            tok_lo = b;
                            phase = PH_TOK_HIGH;
                        end else begin
                            lit_left = b;
                            if (b == 0) end_chunk();
                            else phase = PH_LITERAL;
                        end
                    end
                    PH_LITERAL: begin
                        r.out_byte = b;
                        r.out_valid = 1'b1;
                        put_byte(b);
                        lit_left = lit_left - 1;
                        if (lit_left == 0) begin
                            end_chunk();
                        end else if (done()) begin
                            lit_left = '0;
                            end_chunk();
                            r.err = ERR_TRUNCATED;
                        end
                    end
                    PH_TOK_HIGH: begin
                        tok_hi = b;
                        tok = {b, tok_lo};
                        if (tok[3])
                            r.err = start_match(tok[15:4], 13'(tok[2:0]) + 13'd4);
                        else phase = PH_LONG;
                    end
                    PH_LONG: r.err = start_match(tok[15:4], {1'b0, tok[3:0], b} + 13'd4);
                    PH_COPY: r.err = ERR_WRONG_CMD;
                    default: phase = PH_FLAG;
                endcase
            end
            r.copy_pending = (phase == PH_COPY);
            r.finished = done();
            pending_q.push_back(r);
        endfunction

        function void check_word(t_dec_res got);
            t_dec_res want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %b %h %b %b %0d got %b %h %b %b %0d",
                        want.out_valid, want.out_byte, want.copy_pending, want.finished,
                        want.err, got.out_valid, got.out_byte, got.copy_pending,
                        got.finished, got.err);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LEN_BITS-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_cmd = 1'b0;
    logic [7:0]          i_in_byte = '0;
    logic                o_res_valid;
    logic                i_res_stall = 1'b0;
    logic                o_out_valid;
    logic [7:0]          o_out_byte;
    logic                o_copy_pending;
    logic                o_finished;
    logic [1:0]          o_error_code;

    lz_scoreboard sb;
    int           idle_cycles = 0;
    int           n_sent = 0;
    bit           hold_rx = 1'b0;
    bit           rx_idle_on = 1'b1;
    bit           tx_idle_on = 1'b1;

    lz_flag_byte_decompressor u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall)
            sb.check_word({o_out_valid, o_out_byte, o_copy_pending, o_finished,
                t_err'(o_error_code)});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_res_valid && !i_res_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 3) return $urandom_range(20, 60);
        return $urandom_range(0, 99) < 60 ? 0 : $urandom_range(1, 3);
    endfunction

    always @(posedge i_clk) begin
        if (hold_rx) i_res_stall <= 1'b1;
        else if (rx_idle_on) i_res_stall <= ($urandom_range(0, 99) < 25);
        else i_res_stall <= 1'b0;
    end

    task automatic send_word(logic cmd, logic [7:0] b);
        int g;
        g = tx_idle_on ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(cmd, b);
        n_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_len(logic [23:0] len);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.total_len = len;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_copy();
        while (sb.phase == PH_COPY) send_word(CMD_DRAIN, 8'($urandom));
    endtask

    task automatic send_frame(int chunks);
        logic [7:0]  flags;
        logic [11:0] mdist;
        int          n;
        flags = 8'($urandom);
        send_word(CMD_FEED, flags);
        for (int c = 0; c < 8 && c < chunks; c++) begin
            if (!flags[c]) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 6);
                send_word(CMD_FEED, 8'(n));
                for (int k = 0; k < n; k++) send_word(CMD_FEED, 8'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0) mdist = 12'($urandom);
                else mdist = 12'($urandom_range(1, (sb.produced > 40) ? 40 : 2));
                if ($urandom_range(0, 1)) begin
                    send_word(CMD_FEED, {mdist[3:0], 1'b1, 3'($urandom)});
                    send_word(CMD_FEED, mdist[11:4]);
                end else begin
                    send_word(CMD_FEED, {mdist[3:0], 1'b0,
                        (($urandom_range(0, 31) == 0) ? 3'd1 : 3'd0)});
                    send_word(CMD_FEED, mdist[11:4]);
                    send_word(CMD_FEED, ($urandom_range(0, 15) == 0)
                        ? 8'($urandom) : 8'($urandom_range(0, 8)));
                end
                if ($urandom_range(0, 19) == 0) send_word(CMD_FEED, 8'($urandom));
                drain_copy();
            end
            if (sb.phase == PH_FLAG) break;
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_len(24'd0);
        send_word(CMD_FEED, 8'h00);
        send_word(CMD_DRAIN, 8'h00);
        write_len(24'hFFFFFF);
        send_word(CMD_DRAIN, 8'h00);
        send_word(CMD_FEED, 8'hFE);
        send_word(CMD_FEED, 8'h03);
        send_word(CMD_FEED, 8'h00);
        send_word(CMD_FEED, 8'hFF);
        send_word(CMD_FEED, 8'h5A);
        send_word(CMD_FEED, 8'h00);
        send_word(CMD_FEED, 8'h18);
        send_word(CMD_FEED, 8'h00);
        send_word(CMD_FEED, 8'h1F);
        send_word(CMD_FEED, 8'h00);
        send_word(CMD_FEED, 8'h55);
        drain_copy();
        send_word(CMD_FEED, 8'h30);
        send_word(CMD_FEED, 8'h00);
        send_word(CMD_FEED, 8'h02);
        send_word(CMD_FEED, 8'h00);
        drain_copy();
        send_word(CMD_FEED, 8'h01);
        send_word(CMD_FEED, 8'hFF);

        wait_drained();
        write_len(24'(sb.produced + 3));
        send_frame(8);
        tx_idle_on = 1'b0;
        hold_rx = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            send_frame(8);
        join
        tx_idle_on = 1'b1;
        write_len(24'hFFFFFF);

        while (n_sent < 1300) begin
            if ($urandom_range(0, 19) == 0) send_word(1'($urandom), 8'($urandom));
            else send_frame(8);
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
                write_len(24'(sb.produced + $urandom_range(0, 30)));
            end else if ($urandom_range(0, 29) == 0) begin
                write_len(24'hFFFFFF);
            end
            if ($urandom_range(0, 29) == 0) begin
                rx_idle_on = ~rx_idle_on;
                wait_drained();
            end
        end
        write_len(24'd0);
        send_word(CMD_FEED, 8'h00);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
